// ----- sv/thls_pkg.sv -----
// Shared constants and types for the text header line skipper.
// No dependencies; imported by thls_scan and text_header_line_skipper.
package thls_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_FIXED = 2'd0;
  localparam logic [PHASE_W-1:0] PH_EXTRA = 2'd1;

  localparam int MATCH_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_TO_SKIP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_EMPTY_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_LEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_BYTES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_AWARE     = 3'd4;

  typedef struct packed {
    logic [31:0] data_offset;
    logic [31:0] skipped_rows;
    logic        hit_end;
  } thls_result_t;

endpackage

// ----- sv/thls_scan.sv -----
// Per-byte scan state and next-state logic of the header line skipper.
// Depends on thls_pkg; instantiated by text_header_line_skipper.
module thls_scan import thls_pkg::*; #(
  parameter int COMMENT_MAX = 8,
  parameter int OFFSET_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        rows_to_skip_i,
  input  logic               skip_empty_rows_i,
  input  logic [3:0]         comment_len_i,
  input  logic [63:0]        comment_bytes_i,
  input  logic               quote_aware_i,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output logic               fire_o,
  output thls_result_t       res_o
);

  logic                   first_q;
  logic [PHASE_W-1:0]     phase_q, ph;
  logic [15:0]            rows_left_q, rl;
  logic [OFFSET_BITS-1:0] pos_q, pos_next;
  logic [OFFSET_BITS-1:0] lsp_q, lsp, eoff;
  logic [MATCH_W-1:0]     pmi_q, pmi;
  logic                   lic_q, lic;
  logic                   iq_q, iq;
  logic                   pcr_q, pcr;
  logic                   als_q, als;
  logic                   fin_q, fin;
  logic                   pd_q, pd;
  logic [31:0]            rc_q, rc;
  logic [3:0]             clen;
  logic [7:0]             want;
  logic                   body, emit, eend, is_eol;

  always_comb begin
    clen     = (comment_len_i > 4'(COMMENT_MAX)) ? 4'(COMMENT_MAX) : comment_len_i;
    pos_next = (pos_q == '1) ? pos_q : pos_q + 1'b1;
    is_eol   = (data_byte_i == CH_LF) || (data_byte_i == CH_CR);
    ph       = first_q ? PH_FIXED : phase_q;
    rl       = first_q ? rows_to_skip_i : rows_left_q;
    lsp      = lsp_q;
    pmi      = pmi_q;
    lic      = lic_q;
    iq       = iq_q;
    pcr      = pcr_q;
    als      = als_q;
    fin      = fin_q;
    pd       = pd_q;
    rc       = rc_q;
    body     = 1'b1;
    emit     = 1'b0;
    eend     = 1'b0;
    eoff     = lsp_q;
    want     = 8'h00;
    if (!fin) begin
      if (als) begin
        if (pcr && data_byte_i == CH_LF) begin
          pcr  = 1'b0;
          lsp  = pos_next;
          body = 1'b0;
        end else begin
          pcr = 1'b0;
          if (ph == PH_FIXED && rl == '0) begin
            ph = PH_EXTRA;
          end
          als = 1'b0;
          pmi = '0;
          lic = 1'b0;
          iq  = 1'b0;
          pd  = (clen == '0);
          if (ph == PH_FIXED) begin
            rl = rl - 1'b1;
            rc = (rc == '1) ? rc : rc + 1'b1;
          end else if (skip_empty_rows_i && is_eol) begin
            rc   = (rc == '1) ? rc : rc + 1'b1;
            pcr  = (data_byte_i == CH_CR);
            als  = 1'b1;
            lsp  = pos_next;
            body = 1'b0;
          end
        end
      end
      if (body) begin
        if (iq) begin
          if (data_byte_i == CH_QUOTE) begin
            iq = 1'b0;
          end
        end else begin
          if (!pd && !lic) begin
            want = comment_bytes_i[{pmi[2:0], 3'b000} +: 8];
            if (data_byte_i == want) begin
              pmi = pmi + 1'b1;
              if (pmi >= clen) begin
                lic = 1'b1;
                if (ph == PH_EXTRA) begin
                  rc = (rc == '1) ? rc : rc + 1'b1;
                end
              end
            end else begin
              pd = 1'b1;
            end
          end
          if (ph == PH_EXTRA && pd) begin
            emit = 1'b1;
            eoff = lsp;
            eend = 1'b0;
            fin  = 1'b1;
          end else if (is_eol) begin
            pcr = (data_byte_i == CH_CR);
            als = 1'b1;
            lsp = pos_next;
          end else if (data_byte_i == CH_QUOTE && quote_aware_i && ph == PH_FIXED && !lic) begin
            iq = 1'b1;
          end
        end
      end
    end
    if (last_byte_i && !fin) begin
      emit = 1'b1;
      fin  = 1'b1;
      if (ph == PH_EXTRA && !als && !lic && !pd) begin
        eoff = lsp;
        eend = 1'b0;
      end else begin
        eoff = pos_next;
        eend = 1'b1;
      end
    end
  end

  assign fire_o             = emit;
  assign res_o.data_offset  = 32'(eoff);
  assign res_o.skipped_rows = rc;
  assign res_o.hit_end      = eend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      phase_q     <= PH_FIXED;
      rows_left_q <= '0;
      pos_q       <= '0;
      lsp_q       <= '0;
      pmi_q       <= '0;
      lic_q       <= 1'b0;
      iq_q        <= 1'b0;
      pcr_q       <= 1'b0;
      als_q       <= 1'b1;
      fin_q       <= 1'b0;
      pd_q        <= 1'b0;
      rc_q        <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        first_q     <= 1'b1;
        phase_q     <= PH_FIXED;
        rows_left_q <= '0;
        pos_q       <= '0;
        lsp_q       <= '0;
        pmi_q       <= '0;
        lic_q       <= 1'b0;
        iq_q        <= 1'b0;
        pcr_q       <= 1'b0;
        als_q       <= 1'b1;
        fin_q       <= 1'b0;
        pd_q        <= 1'b0;
        rc_q        <= '0;
      end else begin
        first_q     <= 1'b0;
        phase_q     <= ph;
        rows_left_q <= rl;
        pos_q       <= pos_next;
        lsp_q       <= lsp;
        pmi_q       <= pmi;
        lic_q       <= lic;
        iq_q        <= iq;
        pcr_q       <= pcr;
        als_q       <= als;
        fin_q       <= fin;
        pd_q        <= pd;
        rc_q        <= rc;
      end
    end
  end

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> first_q && pos_q == '0 && rc_q == '0)
    else $error("scan not rearmed after final byte");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !fire_o)
    else $error("second result within one buffer");

  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> pos_q == '0 && !fin_q)
    else $error("first-byte flag out of step with position");

endmodule

// ----- sv/text_header_line_skipper.sv -----
// Top level of the text header line skipper: configuration registers,
// result register and handshakes. Depends on thls_pkg and thls_scan.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   data_byte_i, last_byte_i
//   out      output     out_valid_o/out_ready_i data_offset_o, skipped_rows_o, hit_end_o
//   cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// One byte per cycle while in_ready_o is high; each byte updates the scan state in
// the cycle it is taken, and a result shows on the output register the next cycle.
// Reset clears the configuration to zero and rearms the scan for a new buffer.
// A pending result stalls only a byte that would produce another result;
// other bytes keep flowing while the result waits.
module text_header_line_skipper import thls_pkg::*; #(
  parameter int COMMENT_MAX = 8,
  parameter int OFFSET_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           data_offset_o,
  output logic [31:0]           skipped_rows_o,
  output logic                  hit_end_o
);

  logic [15:0]  rows_to_skip_q;
  logic         skip_empty_rows_q;
  logic [3:0]   comment_len_q;
  logic [63:0]  comment_bytes_q;
  logic         quote_aware_q;
  logic         out_valid_q;
  thls_result_t res_q;
  thls_result_t res;
  logic         fire;
  logic         step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_to_skip_q    <= '0;
      skip_empty_rows_q <= 1'b0;
      comment_len_q     <= '0;
      comment_bytes_q   <= '0;
      quote_aware_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS_TO_SKIP:    rows_to_skip_q    <= cfg_data_i[15:0];
        CFG_SKIP_EMPTY_ROWS: skip_empty_rows_q <= cfg_data_i[0];
        CFG_COMMENT_LEN:     comment_len_q     <= cfg_data_i[3:0];
        CFG_COMMENT_BYTES:   comment_bytes_q   <= cfg_data_i;
        CFG_QUOTE_AWARE:     quote_aware_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  thls_scan #(
    .COMMENT_MAX(COMMENT_MAX),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk_i,
    .rst_ni,
    .rows_to_skip_i    (rows_to_skip_q),
    .skip_empty_rows_i (skip_empty_rows_q),
    .comment_len_i     (comment_len_q),
    .comment_bytes_i   (comment_bytes_q),
    .quote_aware_i     (quote_aware_q),
    .step_i            (step),
    .data_byte_i,
    .last_byte_i,
    .fire_o            (fire),
    .res_o             (res)
  );

  assign in_ready_o = !out_valid_q || out_ready_i || !fire;
  assign step       = in_valid_i && in_ready_o;

  // hold the result until its transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_offset_o  = res_q.data_offset;
  assign skipped_rows_o = res_q.skipped_rows;
  assign hit_end_o      = res_q.hit_end;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && step |-> !fire)
    else $error("pending result overwritten");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && fire))
    else $error("result raised without a producing byte");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("waiting result dropped or changed");

endmodule

// ----- dv/tb.sv -----
// Testbench for text_header_line_skipper: streams text buffers, mirrors the scan
// in a scoreboard class and checks every result field by field.
// Depends on thls_pkg and the text_header_line_skipper RTL.
module tb;
  import thls_pkg::*;

  localparam int COMMENT_MAX = 8;
  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 6;

  typedef enum {LINE_EMPTY, LINE_TEXT, LINE_QUOTED, LINE_COMMENT, LINE_PARTIAL} line_kind_e;

  class header_scoreboard;
    logic [15:0] rows_to_skip;
    logic        skip_empty;
    logic [3:0]  comment_len;
    logic [63:0] comment_bytes;
    logic        quote_aware;

    logic [PHASE_W-1:0] phase;
    logic [15:0]        rows_left;
    logic [31:0]        byte_pos;
    logic [31:0]        line_start;
    logic [MATCH_W-1:0] match_idx;
    logic               line_is_comment;
    logic               in_quote;
    logic               pending_cr;
    logic               at_line_start;
    logic               reported;
    logic               prefix_dead;
    logic [31:0]        row_count;

    thls_result_t offset_q[$];
    int mismatches;
    int found_count;
    int end_count;

    function new();
      rows_to_skip  = '0;
      skip_empty    = 1'b0;
      comment_len   = '0;
      comment_bytes = '0;
      quote_aware   = 1'b0;
      mismatches    = 0;
      found_count   = 0;
      end_count     = 0;
      rearm();
    endfunction

    function void rearm();
      phase           = PH_FIXED;
      rows_left       = rows_to_skip;
      byte_pos        = '0;
      line_start      = '0;
      match_idx       = '0;
      line_is_comment = 1'b0;
      in_quote        = 1'b0;
      pending_cr      = 1'b0;
      at_line_start   = 1'b1;
      row_count       = '0;
      reported        = 1'b0;
      prefix_dead     = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
      case (idx)
        CFG_ROWS_TO_SKIP:    rows_to_skip  = value[15:0];
        CFG_SKIP_EMPTY_ROWS: skip_empty    = value[0];
        CFG_COMMENT_LEN:     comment_len   = value[3:0];
        CFG_COMMENT_BYTES:   comment_bytes = value;
        CFG_QUOTE_AWARE:     quote_aware   = value[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_inc(logic [31:0] p);
      return (p == '1) ? p : p + 32'd1;
    endfunction

    function void count_row();
      if (row_count != '1) row_count++;
    endfunction

    function int pending();
      return offset_q.size();
    endfunction

    // Advance the scan by one byte and queue the result it causes, if any.
    function void note_byte(logic [7:0] b, logic last);
      logic [3:0]   clen;
      logic [31:0]  pos;
      logic         body;
      logic         emitted;
      logic [7:0]   want;
      thls_result_t r;
      clen    = (comment_len > 4'(COMMENT_MAX)) ? 4'(COMMENT_MAX) : comment_len;
      pos     = byte_pos;
      emitted = 1'b0;
      r       = '0;
      if (pos == '0) begin
        phase     = PH_FIXED;
        rows_left = rows_to_skip;
      end
      if (!reported) begin
        body = 1'b1;
        if (at_line_start) begin
          if (pending_cr && b == CH_LF) begin
            pending_cr = 1'b0;
            line_start = sat_inc(pos);
            body       = 1'b0;
          end else begin
            pending_cr = 1'b0;
            if (phase == PH_FIXED && rows_left == '0) phase = PH_EXTRA;
            at_line_start   = 1'b0;
            match_idx       = '0;
            line_is_comment = 1'b0;
            in_quote        = 1'b0;
            prefix_dead     = (clen == '0);
            if (phase == PH_FIXED) begin
              rows_left--;
              count_row();
            end else if (skip_empty && (b == CH_LF || b == CH_CR)) begin
              count_row();
              pending_cr    = (b == CH_CR);
              at_line_start = 1'b1;
              line_start    = sat_inc(pos);
              body          = 1'b0;
            end
          end
        end
        if (body) begin
          if (in_quote) begin
            if (b == CH_QUOTE) in_quote = 1'b0;
          end else begin
            if (!prefix_dead && !line_is_comment) begin
              want = comment_bytes[8*match_idx[2:0] +: 8];
              if (b == want) begin
                match_idx++;
                if (match_idx >= clen) begin
                  line_is_comment = 1'b1;
                  if (phase == PH_EXTRA) count_row();
                end
              end else begin
                prefix_dead = 1'b1;
              end
            end
            if (phase == PH_EXTRA && prefix_dead) begin
              r.data_offset  = line_start;
              r.skipped_rows = row_count;
              r.hit_end      = 1'b0;
              reported       = 1'b1;
              emitted        = 1'b1;
            end else if (b == CH_LF || b == CH_CR) begin
              pending_cr    = (b == CH_CR);
              at_line_start = 1'b1;
              line_start    = sat_inc(pos);
            end else if (b == CH_QUOTE && quote_aware && phase == PH_FIXED && !line_is_comment) begin
              in_quote = 1'b1;
            end
          end
        end
      end
      byte_pos = sat_inc(pos);
      if (last) begin
        if (!reported) begin
          r.skipped_rows = row_count;
          if (phase == PH_EXTRA && !at_line_start && !line_is_comment && !prefix_dead) begin
            r.data_offset = line_start;
            r.hit_end     = 1'b0;
          end else begin
            r.data_offset = byte_pos;
            r.hit_end     = 1'b1;
          end
          emitted = 1'b1;
        end
        rearm();
      end
      if (emitted) offset_q.push_back(r);
    endfunction

    task report(string msg);
      if (mismatches < 30) $display("ERROR: %s", msg);
      mismatches++;
    endtask

    task compare_result(logic [31:0] offset, logic [31:0] rows, logic end_flag);
      thls_result_t want_r;
      if (offset_q.size() == 0) begin
        report($sformatf("result with nothing pending: offset %0d rows %0d end %0b",
                         offset, rows, end_flag));
      end else begin
        want_r = offset_q.pop_front();
        if (want_r.hit_end) end_count++;
        else found_count++;
        if (offset !== want_r.data_offset)
          report($sformatf("data_offset %0d, want %0d", offset, want_r.data_offset));
        if (rows !== want_r.skipped_rows)
          report($sformatf("skipped_rows %0d, want %0d", rows, want_r.skipped_rows));
        if (end_flag !== want_r.hit_end)
          report($sformatf("hit_end %0b, want %0b", end_flag, want_r.hit_end));
      end
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            data_byte_i = '0;
  logic                  last_byte_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [31:0]           data_offset_o;
  logic [31:0]           skipped_rows_o;
  logic                  hit_end_o;

  header_scoreboard sb;
  logic [7:0] text_q[$];
  int src_idle  = 25;
  int sink_idle = 56;
  int items_sent;
  int buffers_sent;
  int configs_written;
  int cycles;

  text_header_line_skipper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_offset_o (data_offset_o),
    .skipped_rows_o(skipped_rows_o),
    .hit_end_o     (hit_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.compare_result(data_offset_o, skipped_rows_o, hit_end_o);
      if (in_valid_i && in_ready_o)
        sb.note_byte(data_byte_i, last_byte_i);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input logic [15:0] rows, input logic skip, input logic [3:0] clen,
                           input logic [63:0] pfx, input logic quote);
    write_reg(CFG_ROWS_TO_SKIP, 64'(rows));
    write_reg(CFG_SKIP_EMPTY_ROWS, 64'(skip));
    write_reg(CFG_COMMENT_LEN, 64'(clen));
    write_reg(CFG_COMMENT_BYTES, pfx);
    write_reg(CFG_QUOTE_AWARE, 64'(quote));
    cfg_we_i <= 1'b0;
    configs_written++;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < text_q.size(); i++) begin
      if (items_sent < ITEM_TARGET / 3) begin
        src_idle  = 25;
        sink_idle = 56;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        src_idle  = 56;
        sink_idle = 25;
      end else begin
        src_idle  = 0;
        sink_idle = 0;
      end
      while ($urandom_range(99) < src_idle) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      data_byte_i <= text_q[i];
      last_byte_i <= (i == text_q.size() - 1);
      do @(posedge clk_i); while (!in_ready_o);
      items_sent++;
    end
    buffers_sent++;
  endtask

  function automatic int prefix_len();
    return (sb.comment_len > 4'(COMMENT_MAX)) ? COMMENT_MAX : int'(sb.comment_len);
  endfunction

  function automatic logic [7:0] prefix_byte(int k);
    return sb.comment_bytes[8*k +: 8];
  endfunction

  function automatic logic [7:0] marker_byte();
    int r;
    r = $urandom_range(19);
    case (r)
      0: return CH_LF;
      1: return CH_CR;
      2: return CH_QUOTE;
      default: begin
        case (r % 4)
          0: return "#";
          1: return "/";
          2: return "!";
          default: return ";";
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(19);
    if (r < 10) return 8'("a") + 8'(r);
    case (r)
      10, 11: return ",";
      12: return " ";
      13: return CH_QUOTE;
      14: return prefix_byte(0);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0: return CH_LF;
      1: return CH_CR;
      2: return CH_QUOTE;
      3: return prefix_byte(0);
      4: return "a";
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_text(int lo, int hi);
    repeat ($urandom_range(lo, hi)) text_q.push_back(text_byte());
  endfunction

  function automatic void add_eol();
    case ($urandom_range(2))
      0: text_q.push_back(CH_LF);
      1: text_q.push_back(CH_CR);
      default: begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end
    endcase
  endfunction

  function automatic void add_line(line_kind_e kind);
    int clen;
    int lim;
    clen = prefix_len();
    case (kind)
      LINE_TEXT: add_text(1, 6);
      LINE_QUOTED: begin
        add_text(0, 2);
        text_q.push_back(CH_QUOTE);
        add_text(0, 3);
        add_eol();
        add_text(0, 3);
        text_q.push_back(CH_QUOTE);
        add_text(0, 2);
      end
      LINE_COMMENT: begin
        for (int k = 0; k < clen; k++) text_q.push_back(prefix_byte(k));
        add_text(0, 4);
      end
      LINE_PARTIAL: begin
        lim = (clen > 0) ? $urandom_range(0, clen - 1) : 0;
        for (int k = 0; k < lim; k++) text_q.push_back(prefix_byte(k));
        add_text(1, 4);
      end
      default: ;
    endcase
    add_eol();
  endfunction

  function automatic void make_buffer();
    int fixed_lines;
    int cut;
    text_q.delete();
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(1, 16)) text_q.push_back(noise_byte());
    end else begin
      fixed_lines = (sb.rows_to_skip <= 6) ? int'(sb.rows_to_skip) : $urandom_range(0, 6);
      repeat (fixed_lines) add_line(line_kind_e'($urandom_range(4)));
      repeat ($urandom_range(0, 4))
        add_line(($urandom_range(2) == 0) ? LINE_EMPTY : LINE_COMMENT);
      repeat ($urandom_range(0, 2)) add_line(LINE_TEXT);
      if (text_q.size() > 1 && $urandom_range(9) < 3) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
    end
    if (text_q.size() == 0) text_q.push_back(text_byte());
  endfunction

  task automatic random_config();
    logic [15:0] rows;
    logic [3:0]  clen;
    logic [63:0] pfx;
    int r;
    r = $urandom_range(9);
    if (r < 4) rows = '0;
    else if (r < 8) rows = 16'($urandom_range(1, 4));
    else if (r == 8) rows = 16'hFFFF;
    else rows = 16'($urandom_range(5, 300));
    r = $urandom_range(9);
    if (r < 2) clen = '0;
    else if (r < 7) clen = 4'($urandom_range(1, 3));
    else if (r == 7) clen = 4'(COMMENT_MAX);
    else if (r == 8) clen = 4'($urandom_range(9, 15));
    else clen = 4'($urandom_range(4, 7));
    pfx = {$urandom, $urandom};
    for (int k = 0; k < COMMENT_MAX; k++)
      if (k < clen) pfx[8*k +: 8] = marker_byte();
    configure(rows, 1'($urandom_range(1)), clen, pfx, 1'($urandom_range(1)));
  endtask

  initial begin
    sb = new();
    items_sent      = 0;
    buffers_sent    = 0;
    configs_written = 0;
    cycles          = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one-byte buffers at both byte extremes
    text_q = '{8'h00};
    send_buffer();
    text_q = '{8'hFF};
    send_buffer();

    // quoted span across a line end, CR LF empty line, comment with lone CR,
    // buffer ending inside a partial prefix
    quiesce();
    configure(16'd1, 1'b1, 4'd2, 64'h0000_0000_0000_2123, 1'b1);
    text_q = '{CH_QUOTE, "a", CH_LF, "b", CH_QUOTE, CH_LF, CH_CR, CH_LF,
               "#", "!", "c", CH_CR, "#"};
    send_buffer();

    // oversized prefix length holding line-end and quote bytes; bytes after the result
    quiesce();
    configure(16'd0, 1'b0, 4'd15, 64'hFF00_2222_0D22_220A, 1'b0);
    text_q = '{CH_LF, "X", "Y"};
    send_buffer();

    // largest fixed skip, all-ones prefix
    quiesce();
    configure(16'hFFFF, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    text_q = '{CH_CR, CH_LF};
    send_buffer();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(3) == 0) begin
        quiesce();
        random_config();
      end
      make_buffer();
      send_buffer();
    end

    quiesce();
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Scanned %0d buffers (%0d bytes) under %0d register settings.",
             buffers_sent, items_sent, configs_written);
    $display("Results: %0d found a data line, %0d ran to the buffer end, %0d mismatches.",
             sb.found_count, sb.end_count, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
